>>> design/p1_triangle_laplace_stiffness_unit_defines.svh
// ----------------------------------------------------------------------------
// p1 triangle stiffness unit: assertion macros
// shared check macros, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef P1_TRIANGLE_LAPLACE_STIFFNESS_UNIT_DEFINES_SVH
`define P1_TRIANGLE_LAPLACE_STIFFNESS_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define P1TLS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("p1tls check failed");
`define P1TLS_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("p1tls check failed");
`else
`define P1TLS_ASSERT(lbl, clk, rst, prop)
`define P1TLS_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

>>> design/p1tls_pkg.sv
// ----------------------------------------------------------------------------
// p1tls_pkg
// constants and types shared by the triangle stiffness unit
// ----------------------------------------------------------------------------
package p1tls_pkg;

   localparam int CoordWidthDef = 32;
   localparam int FracBitsDef   = 16;

   localparam int EntryWidth  = 48;
   localparam int HalfWidth   = EntryWidth / 2;
   localparam int QuotBits    = EntryWidth + 1;
   localparam int RowBits     = 2;
   localparam int RspDataBits = RowBits + 4 * EntryWidth;
   localparam int RspDataWidth = ((RspDataBits + 7) / 8) * 8;

   localparam logic [RowBits-1:0] LastRow = RowBits'(2);

   localparam int QueueDepth = 4;
   localparam int QPtrWidth  = $clog2(QueueDepth);
   localparam int QCntWidth  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic                 empty;
      logic [QCntWidth-1:0] count;
   } q_stat_type;

endpackage

>>> design/p1_triangle_laplace_stiffness_unit.sv
// ----------------------------------------------------------------------------
// p1_triangle_laplace_stiffness_unit
// element stiffness matrix and rhs of one linear triangle, row by row
// ----------------------------------------------------------------------------
// req channel: one word per triangle, nine signed fixed point fields.
// rsp channel: three words per triangle, rows 0, 1, 2 in order; tlast marks
// row 2, tuser flags a zero determinant (entries and rhs then zero).
// front: two register stages (normals, determinant products) feed a
// four-word queue; req_tready counts queue space including items in flight,
// so a new triangle is taken every cycle while space remains.
// back: per entry a multiply state, a sum state, a 49-step restoring
// divider (one quotient bit a cycle) and a store; per row an rhs pass on a
// split 24-bit by coordinate multiplier and an emit state. the back
// sequencer takes one triangle at a time and sets the throughput; a
// degenerate triangle skips the arithmetic and goes straight to its rows.
// results sit in an output register; a stalled receiver holds the back
// sequencer while the front keeps filling the queue.
// reset is synchronous and empties queue, pipeline and output register.
// ----------------------------------------------------------------------------
module p1_triangle_laplace_stiffness_unit #(
   parameter int COORD_WIDTH = p1tls_pkg::CoordWidthDef,
   parameter int FRAC_BITS   = p1tls_pkg::FracBitsDef
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // x_a, y_a, x_b, y_b, x_c, y_c, u_a, u_b, u_c, zero fill
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // row_index, entry_0, entry_1, entry_2, rhs_value, zero fill
   output logic [p1tls_pkg::RspDataWidth-1:0]      rsp_tdata,
   // degenerate
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast
);
   import p1tls_pkg::*;

   localparam int NW = COORD_WIDTH + 1;
   localparam int LW = 6 * NW + 2 * NW + 1 + 1 + 3 * COORD_WIDTH;

   q_stat_type     q_stat;
   logic           push, pop, q_valid;
   logic [LW-1:0]  push_data, pop_data;

   p1tls_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_fields (req_tdata[9*COORD_WIDTH-1:0]),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data)
   );

   p1tls_fifo #(.WIDTH(LW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_valid   (q_valid),
      .q_stat    (q_stat)
   );

   p1tls_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> design/p1tls_fifo.sv
// ----------------------------------------------------------------------------
// p1tls_fifo
// short queue between the front stage and the back sequencer
// ----------------------------------------------------------------------------
module p1tls_fifo #(
   parameter int WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       pop_data,
   output logic                   q_valid,
   output p1tls_pkg::q_stat_type  q_stat
);
   import p1tls_pkg::*;

   logic [WIDTH-1:0]     mem_ff [QueueDepth];
   logic [QPtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntWidth-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPtrWidth'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPtrWidth'(1);
         case ({push, pop})
            2'b10:   count_ff <= count_ff + QCntWidth'(1);
            2'b01:   count_ff <= count_ff - QCntWidth'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign q_valid      = (count_ff != '0);
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.count = count_ff;

endmodule

>>> design/p1tls_front.sv
// ----------------------------------------------------------------------------
// p1tls_front
// accepts triangles, forms edge normals and the determinant, flags degenerate
// ----------------------------------------------------------------------------
module p1tls_front #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [9*COORD_WIDTH-1:0]   req_fields,
   input  p1tls_pkg::q_stat_type      q_stat,
   output logic                       push,
   output logic [6*(COORD_WIDTH+1)+2*(COORD_WIDTH+1)+1+1+3*COORD_WIDTH-1:0] push_data
);
   import p1tls_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int NW = CW + 1;
   localparam int PW = 2 * NW;
   localparam int DW = PW + 1;
   localparam int OW = QCntWidth + 1;

   logic signed [CW-1:0] fx [3];
   logic signed [CW-1:0] fy [3];
   logic signed [CW-1:0] fu [3];
   logic signed [NW-1:0] nx_in [3];
   logic signed [NW-1:0] ny_in [3];

   logic signed [NW-1:0] nxa_ff [3];
   logic signed [NW-1:0] nya_ff [3];
   logic signed [CW-1:0] ua_ff  [3];
   logic                 va_ff;

   logic signed [NW-1:0] nxb_ff [3];
   logic signed [NW-1:0] nyb_ff [3];
   logic signed [CW-1:0] ub_ff  [3];
   logic signed [PW-1:0] pd1_ff, pd2_ff;
   logic                 vb_ff;

   logic signed [DW-1:0] det;
   logic                 degen;
   logic [OW-1:0]        occupancy;
   logic                 accept;

   for (genvar i = 0; i < 3; i++) begin : g_vert
      localparam int P = (i + 1) % 3;
      localparam int Q = (i + 2) % 3;
      assign fx[i]    = req_fields[(2*i)*CW +: CW];
      assign fy[i]    = req_fields[(2*i+1)*CW +: CW];
      assign fu[i]    = req_fields[(6+i)*CW +: CW];
      assign nx_in[i] = NW'(fy[P]) - NW'(fy[Q]);
      assign ny_in[i] = NW'(fx[Q]) - NW'(fx[P]);
   end

   // items in flight count against queue space so the pipe never stalls
   assign occupancy  = OW'(q_stat.count) + OW'(va_ff) + OW'(vb_ff);
   assign req_tready = (occupancy < OW'(QueueDepth));
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= accept;
         vb_ff <= va_ff;
      end
      for (int i = 0; i < 3; i++) begin
         nxa_ff[i] <= nx_in[i];
         nya_ff[i] <= ny_in[i];
         ua_ff[i]  <= fu[i];
         nxb_ff[i] <= nxa_ff[i];
         nyb_ff[i] <= nya_ff[i];
         ub_ff[i]  <= ua_ff[i];
      end
      pd1_ff <= nya_ff[2] * nxa_ff[1];
      pd2_ff <= nya_ff[1] * nxa_ff[2];
   end

   assign det   = DW'(pd1_ff) - DW'(pd2_ff);
   assign degen = (det == '0);
   assign push  = vb_ff;
   assign push_data = {ub_ff[2], ub_ff[1], ub_ff[0], degen, det,
                       nyb_ff[2], nyb_ff[1], nyb_ff[0],
                       nxb_ff[2], nxb_ff[1], nxb_ff[0]};

endmodule

>>> design/p1tls_back.sv
// ----------------------------------------------------------------------------
// p1tls_back
// per-entry dot product, rounded division, row rhs and result register
// ----------------------------------------------------------------------------
`include "p1_triangle_laplace_stiffness_unit_defines.svh"

module p1tls_back #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  logic [6*(COORD_WIDTH+1)+2*(COORD_WIDTH+1)+1+1+3*COORD_WIDTH-1:0] q_data,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [p1tls_pkg::RspDataWidth-1:0]  rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import p1tls_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int NW  = CW + 1;
   localparam int PW  = 2 * NW;
   localparam int DW  = PW + 1;
   localparam int LW  = 6 * NW + DW + 1 + 3 * CW;
   localparam int WW  = DW + QuotBits + FRAC_BITS + 4;
   localparam int PRW = HalfWidth + 1 + CW;
   localparam int AW  = EntryWidth + CW + 4;
   localparam int EW  = EntryWidth;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_SUM, S_DIV, S_STORE, S_RHS, S_EMIT
   } state_type;

   state_type            state_ff;
   logic [LW-1:0]        item_ff;
   logic [RowBits-1:0]   row_ff, col_ff;
   logic [2:0]           ph_ff;
   logic [5:0]           cnt_ff;
   logic signed [PW-1:0] pa_ff, pb_ff;
   logic [WW-1:0]        rem_ff, dsh_ff;
   logic [QuotBits-1:0]  q_ff;
   logic                 neg_ff, ovf_ff;
   logic [EW-1:0]        ent_ff [3];
   logic signed [PRW-1:0] prod_ff;
   logic                 prod_hi_ff, prod_v_ff;
   logic signed [AW-1:0] acc_ff;

   logic                 rsp_tvalid_ff, rsp_tuser_ff, rsp_tlast_ff;
   logic [RowBits-1:0]   rsp_row_ff;
   logic [EW-1:0]        rsp_ent_ff [3];
   logic [EW-1:0]        rsp_rhs_ff;

   logic signed [NW-1:0] nx [3];
   logic signed [NW-1:0] ny [3];
   logic signed [CW-1:0] uv [3];
   logic signed [DW-1:0] det;
   logic                 degen;
   logic [DW-1:0]        dmag;
   logic signed [PW:0]   dot;
   logic [PW:0]          dmag_dot;
   logic [WW-1:0]        num_in, rem_in;
   logic                 ge;
   logic [EW-1:0]        ent_in;
   logic [EW-1:0]        ea;
   logic signed [PRW-1:0] prod_in;
   logic signed [AW-1:0] acc_add, rhs_wide;
   logic [AW-EW:0]       rhs_top;
   logic [EW-1:0]        rhs_in;
   logic                 out_free;

   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign nx[i] = item_ff[i*NW +: NW];
      assign ny[i] = item_ff[(3+i)*NW +: NW];
      assign uv[i] = item_ff[6*NW+DW+1+i*CW +: CW];
   end
   assign det   = item_ff[6*NW +: DW];
   assign degen = item_ff[6*NW+DW];
   assign dmag  = det[DW-1] ? DW'(-det) : DW'(det);

   // numerator 2|n.n|*2^F + |2 det| over divisor 4|det|
   assign dot      = (PW+1)'(pa_ff) + (PW+1)'(pb_ff);
   assign dmag_dot = dot[PW] ? (PW+1)'(-dot) : (PW+1)'(dot);
   assign num_in   = (WW'(dmag_dot) << (FRAC_BITS + 1)) + (WW'(dmag) << 1);

   assign ge     = (rem_ff >= dsh_ff);
   assign rem_in = ge ? rem_ff - dsh_ff : rem_ff;

   // saturate the quotient with its sign
   always_comb begin
      if (!neg_ff) begin
         if (ovf_ff || (q_ff[QuotBits-1:EW-1] != '0)) ent_in = {1'b0, {(EW-1){1'b1}}};
         else                                           ent_in = q_ff[EW-1:0];
      end else begin
         if (ovf_ff || (q_ff[QuotBits-1:EW-1] != '0)) ent_in = {1'b1, {(EW-1){1'b0}}};
         else                                           ent_in = EW'(-q_ff[EW-1:0]);
      end
   end

   // rhs partial products: low half unsigned, high half signed
   assign ea = ent_ff[ph_ff[2:1]];
   always_comb begin
      if (ph_ff[0]) prod_in = PRW'($signed(ea[EW-1:HalfWidth])) * PRW'(uv[ph_ff[2:1]]);
      else          prod_in = PRW'($signed({1'b0, ea[HalfWidth-1:0]})) *
                              PRW'(uv[ph_ff[2:1]]);
   end
   assign acc_add = prod_hi_ff ? (AW'(prod_ff) <<< HalfWidth) : AW'(prod_ff);

   assign rhs_wide = acc_ff >>> FRAC_BITS;
   assign rhs_top  = rhs_wide[AW-1:EW-1];
   always_comb begin
      if ((&rhs_top) || !(|rhs_top)) rhs_in = rhs_wide[EW-1:0];
      else if (rhs_top[AW-EW])       rhs_in = {1'b1, {(EW-1){1'b0}}};
      else                           rhs_in = {1'b0, {(EW-1){1'b1}}};
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign pop      = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         ph_ff         <= '0;
         cnt_ff        <= '0;
         prod_v_ff     <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_data;
                  row_ff   <= '0;
                  col_ff   <= '0;
                  state_ff <= q_data[6*NW+DW] ? S_EMIT : S_MUL;
               end
            end
            S_MUL: begin
               pa_ff    <= nx[row_ff] * nx[col_ff];
               pb_ff    <= ny[row_ff] * ny[col_ff];
               state_ff <= S_SUM;
            end
            S_SUM: begin
               rem_ff   <= num_in;
               dsh_ff   <= WW'(dmag) << (QuotBits + 1);
               ovf_ff   <= (num_in >= (WW'(dmag) << (QuotBits + 2)));
               neg_ff   <= dot[PW] ^ det[DW-1];
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= rem_in;
               dsh_ff <= dsh_ff >> 1;
               q_ff   <= {q_ff[QuotBits-2:0], ge};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(QuotBits - 1)) state_ff <= S_STORE;
            end
            S_STORE: begin
               ent_ff[col_ff] <= ent_in;
               if (col_ff == LastRow) begin
                  col_ff    <= '0;
                  ph_ff     <= '0;
                  prod_v_ff <= 1'b0;
                  acc_ff    <= AW'(1) <<< (FRAC_BITS - 1);
                  state_ff  <= S_RHS;
               end else begin
                  col_ff   <= col_ff + RowBits'(1);
                  state_ff <= S_MUL;
               end
            end
            S_RHS: begin
               if (prod_v_ff) acc_ff <= acc_ff + acc_add;
               prod_ff    <= prod_in;
               prod_hi_ff <= ph_ff[0];
               prod_v_ff  <= (ph_ff != 3'd6);
               ph_ff      <= ph_ff + 3'd1;
               if (ph_ff == 3'd6) state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_row_ff    <= row_ff;
                  rsp_tuser_ff  <= degen;
                  rsp_tlast_ff  <= (row_ff == LastRow);
                  for (int j = 0; j < 3; j++) rsp_ent_ff[j] <= degen ? '0 : ent_ff[j];
                  rsp_rhs_ff    <= degen ? '0 : rhs_in;
                  if (row_ff == LastRow) begin
                     state_ff <= S_IDLE;
                  end else begin
                     row_ff   <= row_ff + RowBits'(1);
                     state_ff <= degen ? S_EMIT : S_MUL;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = RspDataWidth'({rsp_rhs_ff, rsp_ent_ff[2], rsp_ent_ff[1],
                                      rsp_ent_ff[0], rsp_row_ff});

   `P1TLS_ASSERT(a_last_is_row2, clock, reset, rsp_tvalid_ff && rsp_tlast_ff |-> rsp_row_ff == LastRow)
   `P1TLS_ASSERT(a_degen_zero, clock, reset, rsp_tvalid_ff && rsp_tuser_ff |-> rsp_rhs_ff == '0 && rsp_ent_ff[0] == '0)
   `P1TLS_ASSERT_NEVER(a_pop_empty, clock, reset, pop && !q_valid)

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: triangle stiffness unit regression
// drives triangles with random gaps, predicts the three rows of stiffness
// entries and rhs per triangle in 128-bit arithmetic, checks every row word
// ----------------------------------------------------------------------------
module tb_top;
   import p1tls_pkg::*;

   localparam int ReqWidth  = 9 * 32;
   localparam int NumRandom = 158;
   localparam int CalmTail  = 30;
   localparam int LongHold  = 6000;
   localparam int DrainWait = 700;
   localparam int CycleLimit = 1500000;
   localparam logic [31:0] One = 32'h0001_0000;

   typedef struct {
      logic [RowBits-1:0]    row;
      logic [EntryWidth-1:0] entry[3];
      logic [EntryWidth-1:0] rhs;
      logic                  degen;
      logic                  last;
   } row_word_type;

   class stiffness_board;
      row_word_type rows_due[$];
      int        n_triangles;
      int        n_degen;
      int        n_rows;
      int        n_errors;

      static function logic [EntryWidth-1:0] clamp48(logic signed [127:0] v);
         if (v > 128'sd140737488355327) return 48'h7FFF_FFFF_FFFF;
         if (v < -128'sd140737488355328) return 48'h8000_0000_0000;
         return v[EntryWidth-1:0];
      endfunction

      // stiffness rows and rhs of one triangle word
      function void note_triangle(logic [ReqWidth-1:0] w);
         logic signed [127:0] x[3], y[3], u[3], nx[3], ny[3];
         logic signed [127:0] det, den, mden, num, mnum, quo, acc, ent;
         logic [EntryWidth-1:0] a[3][3];
         row_word_type r;
         int p, q;
         for (int i = 0; i < 3; i++) begin
            x[i] = $signed(w[64*i +: 32]);
            y[i] = $signed(w[64*i+32 +: 32]);
            u[i] = $signed(w[192+32*i +: 32]);
         end
         for (int i = 0; i < 3; i++) begin
            p = (i + 1) % 3;
            q = (i + 2) % 3;
            nx[i] = y[p] - y[q];
            ny[i] = x[q] - x[p];
         end
         det  = ny[2] * nx[1] - ny[1] * nx[2];
         den  = det <<< 1;
         mden = (den < 0) ? -den : den;
         n_triangles++;
         if (det == 0) n_degen++;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (det == 0) begin
                  a[i][j] = '0;
               end else begin
                  num  = (nx[i] * nx[j] + ny[i] * ny[j]) <<< FracBitsDef;
                  mnum = (num < 0) ? -num : num;
                  // round half away from zero on magnitudes
                  quo  = (2 * mnum + mden) / (2 * mden);
                  if ((num < 0) != (den < 0)) quo = -quo;
                  a[i][j] = clamp48(quo);
               end
            end
         end
         for (int i = 0; i < 3; i++) begin
            r.row   = RowBits'(i);
            r.degen = (det == 0);
            r.last  = (r.row == LastRow);
            for (int j = 0; j < 3; j++) r.entry[j] = a[i][j];
            r.rhs = '0;
            if (det != 0) begin
               acc = 128'sd1 <<< (FracBitsDef - 1);
               for (int j = 0; j < 3; j++) begin
                  ent = $signed(a[i][j]);
                  acc = acc + ent * u[j];
               end
               r.rhs = clamp48(acc >>> FracBitsDef);
            end
            rows_due.push_back(r);
         end
      endfunction

      function void check_row(row_word_type got);
         row_word_type want;
         bit bad;
         n_rows++;
         if (rows_due.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected row word: row %0d", got.row);
            return;
         end
         want = rows_due.pop_front();
         bad = (got.row != want.row) || (got.rhs != want.rhs) ||
               (got.degen != want.degen) || (got.last != want.last);
         for (int j = 0; j < 3; j++) bad |= (got.entry[j] != want.entry[j]);
         if (bad) begin
            n_errors++;
            if (n_errors <= 10) begin
               $display("row mismatch exp: row %0d e %h %h %h rhs %h dg %b last %b",
                        want.row, want.entry[0], want.entry[1], want.entry[2],
                        want.rhs, want.degen, want.last);
               $display("             got: row %0d e %h %h %h rhs %h dg %b last %b",
                        got.row, got.entry[0], got.entry[1], got.entry[2],
                        got.rhs, got.degen, got.last);
            end
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqWidth-1:0]     req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;

   stiffness_board board = new();
   bit  calm = 1'b0;
   bit  held = 1'b0;
   int  cycles = 0;

   p1_triangle_laplace_stiffness_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      row_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row = rsp_tdata[1:0];
         for (int j = 0; j < 3; j++) got.entry[j] = rsp_tdata[2 + 48*j +: 48];
         got.rhs   = rsp_tdata[146 +: 48];
         got.degen = rsp_tuser;
         got.last  = rsp_tlast;
         board.check_row(got);
      end
   end

   // receiver: random stalls, one long hold so the queue fills up
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && board.n_triangles >= 20) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LongHold) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic logic [ReqWidth-1:0] tri_word(
      logic [31:0] xa, logic [31:0] ya, logic [31:0] xb, logic [31:0] yb,
      logic [31:0] xc, logic [31:0] yc, logic [31:0] ua, logic [31:0] ub,
      logic [31:0] uc);
      return {uc, ub, ua, yc, xc, yb, xb, ya, xa};
   endfunction

   task automatic send_triangle(logic [ReqWidth-1:0] w);
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_triangle(w);
      if (!calm && $urandom_range(0, 1) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] span(int bits);
      return 32'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
   endfunction

   function automatic logic [ReqWidth-1:0] random_triangle();
      logic [31:0] v[9];
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) v[i] = span(21);
      case (kind)
         5, 6, 9: begin
            for (int i = 0; i < 9; i++) v[i] = $urandom;
         end
         7: begin
            // third vertex on the line through the first two
            v[4] = v[0] + 2 * (v[2] - v[0]);
            v[5] = v[1] + 2 * (v[3] - v[1]);
         end
         8: begin
            // sliver: long edge, tiny height, entries run into saturation
            v[2] = v[0] + $urandom;
            v[3] = v[1];
            v[4] = v[0];
            v[5] = v[1] + $urandom_range(1, 4);
            for (int i = 6; i < 9; i++) v[i] = $urandom;
         end
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0) for (int i = 6; i < 9; i++) v[i] = $urandom;
      return tri_word(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unit right triangle both windings
      send_triangle(tri_word(0, 0, One, 0, 0, One, One, 2 * One, 3 * One));
      send_triangle(tri_word(0, 0, 0, One, One, 0, One, 2 * One, 3 * One));
      // zero determinant: all at origin, collinear, repeated vertex
      send_triangle(tri_word(0, 0, 0, 0, 0, 0, One, One, One));
      send_triangle(tri_word(0, 0, One, One, 2 * One, 2 * One, 5, 6, 7));
      send_triangle(tri_word(One, 3, One, 3, -One, 7, 32'h7FFF_FFFF, 1, 2));
      // coordinate extremes
      send_triangle(tri_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'hFFFF_FFFF));
      send_triangle(tri_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
      // slivers that saturate entries and rhs
      send_triangle(tri_word(0, 0, 32'h7FFF_FFFF, 0, 0, 1, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000));
      send_triangle(tri_word(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 1,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_triangle(tri_word(0, 0, 1, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1));
      send_triangle(tri_word(-One, -One, 3 * One, -2 * One, One / 2, 5 * One,
                             32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      send_triangle(tri_word(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                             32'hFFFF_0000, 32'h0000_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                             32'hFFFF_FFFF));

      for (int n = 0; n < NumRandom; n++) begin
         if (n == NumRandom - CalmTail) calm = 1'b1;
         send_triangle(random_triangle());
      end
      calm = 1'b1;
      req_tvalid <= 1'b0;

      while (board.rows_due.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      $display("%0d triangles (%0d with zero determinant) sent, %0d row words checked,",
               board.n_triangles, board.n_degen, board.n_rows);
      $display("including saturating slivers, both windings and a long receiver hold");
      if (board.n_errors == 0 && board.rows_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", board.n_errors);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/p1tls_pkg.sv
design/p1tls_fifo.sv
design/p1tls_front.sv
design/p1tls_back.sv
design/p1_triangle_laplace_stiffness_unit.sv
test/tb_top.sv
